/* hw/rtl/sdid_pkg.sv */
// sdid_pkg: shared constants, codes and transaction types for the SD card
// identification sequencer. No dependencies.
package sdid_pkg;

  // block number to byte address shift for standard capacity cards
  localparam int unsigned BlockShift = 9;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDENT_DIV = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DATA_DIV = 2'd2;

  // configuration reset values
  localparam logic [7:0] RETRY_LIMIT_RST = 8'd100;
  localparam logic [9:0] IDENT_DIV_RST = 10'd52;
  localparam logic [9:0] DATA_DIV_RST = 10'd1;

  // event modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_COMPLETE = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  // sequence phases
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_CMD0 = 4'd1;
  localparam logic [3:0] PH_CMD8 = 4'd2;
  localparam logic [3:0] PH_CMD55 = 4'd3;
  localparam logic [3:0] PH_ACMD41 = 4'd4;
  localparam logic [3:0] PH_CMD2 = 4'd5;
  localparam logic [3:0] PH_CMD3 = 4'd6;
  localparam logic [3:0] PH_CMD7 = 4'd7;
  localparam logic [3:0] PH_READY = 4'd8;
  localparam logic [3:0] PH_BLOCK = 4'd9;

  // card kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_V1 = 2'd1;
  localparam logic [1:0] KIND_V2 = 2'd2;
  localparam logic [1:0] KIND_HC = 2'd3;

  // actions and result codes
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ISSUE = 2'd1;
  localparam logic [1:0] ACT_DONE = 2'd2;
  localparam logic [1:0] RES_OK = 2'd0;
  localparam logic [1:0] RES_ERROR = 2'd1;
  localparam logic [1:0] RES_TIMEOUT = 2'd2;

  // command and transfer mode words
  localparam logic [31:0] C_GO_IDLE = 32'h0000_0000;
  localparam logic [31:0] C_SEND_CID = 32'h0201_0000;
  localparam logic [31:0] C_SEND_RCA = 32'h0302_0000;
  localparam logic [31:0] C_SELECT = 32'h0703_0000;
  localparam logic [31:0] C_IF_COND = 32'h0802_0000;
  localparam logic [31:0] C_READ_ONE = 32'h1122_0010;
  localparam logic [31:0] C_WRITE_ONE = 32'h1822_0000;
  localparam logic [31:0] C_APP = 32'h3700_0000;
  localparam logic [31:0] C_OP_COND = 32'h2902_0000;

  // argument and response constants
  localparam logic [11:0] IF_COND_PATTERN = 12'h1AA;
  localparam logic [31:0] OCR_ARG_HC = 32'h40FF_8000;
  localparam logic [31:0] OCR_ARG_SC = 32'h00FF_8000;
  localparam int unsigned OcrBusyBit = 31;
  localparam int unsigned OcrCcsBit = 30;

  typedef struct packed {
    logic [1:0]  mode;
    logic        cmd_ok;
    logic [31:0] resp_word0;
    logic [31:0] resp_word1;
    logic [31:0] resp_word2;
    logic [31:0] resp_word3;
    logic [31:0] block_address;
    logic        is_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] cmd_word;
    logic [31:0] cmd_arg;
    logic [9:0]  clock_div;
    logic [1:0]  card_kind;
    logic [1:0]  result_code;
    logic        card_ready;
  } res_item_t;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [9:0] ident_clock_div;
    logic [9:0] data_clock_div;
  } cfg_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       fast_clock;
  } seq_status_t;

endpackage

/* hw/rtl/sdid_if.sv */
// sdid_in_if and sdid_out_if: valid/ready channels of the sequencer.
// Depends on nothing.
interface sdid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        cmd_ok;
  logic [31:0] resp_word0;
  logic [31:0] resp_word1;
  logic [31:0] resp_word2;
  logic [31:0] resp_word3;
  logic [31:0] block_address;
  logic        is_write;

  modport source (
    output valid, mode, cmd_ok, resp_word0, resp_word1, resp_word2, resp_word3,
           block_address, is_write,
    input  ready
  );
  modport sink (
    input  valid, mode, cmd_ok, resp_word0, resp_word1, resp_word2, resp_word3,
           block_address, is_write,
    output ready
  );
endinterface

interface sdid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] cmd_word;
  logic [31:0] cmd_arg;
  logic [9:0]  clock_div;
  logic [1:0]  card_kind;
  logic [1:0]  result_code;
  logic        card_ready;

  modport source (
    output valid, action, cmd_word, cmd_arg, clock_div, card_kind, result_code,
           card_ready,
    input  ready
  );
  modport sink (
    input  valid, action, cmd_word, cmd_arg, clock_div, card_kind, result_code,
           card_ready,
    output ready
  );
endinterface

/* hw/rtl/sdid_pipe_reg.sv */
// sdid_pipe_reg: one-entry valid/ready pipeline register, full throughput.
// Depends on nothing.
module sdid_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // accept when empty or when the held transaction leaves this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o = data_q;

endmodule

/* hw/rtl/sdid_cfg_regs.sv */
// sdid_cfg_regs: write-only configuration registers of the sequencer.
// Depends on sdid_pkg.
module sdid_cfg_regs
  import sdid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_limit <= RETRY_LIMIT_RST;
      cfg_q.ident_clock_div <= IDENT_DIV_RST;
      cfg_q.data_clock_div <= DATA_DIV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_wdata_i[7:0];
        CFG_IDENT_DIV: cfg_q.ident_clock_div <= cfg_wdata_i;
        CFG_DATA_DIV: cfg_q.data_clock_div <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/sdid_seq.sv */
// sdid_seq: identification state and the single-pass next-state logic that
// turns one event into one result. Depends on sdid_pkg.
module sdid_seq
  import sdid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  in_item_t    item_i,
  input  cfg_t        cfg_i,
  output res_item_t   res_o,
  output seq_status_t status_o
);

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] rca_q, rca_d;
  logic [7:0]  attempts_q, attempts_d;
  logic        fast_q, fast_d;
  logic [31:0] ocr_q;
  logic [31:0] cid_q [4];
  logic        ocr_we, cid_we;

  logic [1:0]  act;
  logic [31:0] word;
  logic [31:0] arg;
  logic [1:0]  res;
  logic [31:0] r0;

  assign r0 = item_i.resp_word0;

  // next state and result for the event at the head of the input register
  always_comb begin
    phase_d = phase_q;
    kind_d = kind_q;
    rca_d = rca_q;
    attempts_d = attempts_q;
    fast_d = fast_q;
    ocr_we = 1'b0;
    cid_we = 1'b0;
    act = ACT_NONE;
    word = '0;
    arg = '0;
    res = RES_OK;
    case (item_i.mode)
      MODE_START: begin
        kind_d = KIND_UNKNOWN;
        rca_d = '0;
        attempts_d = cfg_i.retry_limit;
        fast_d = 1'b0;
        phase_d = PH_CMD0;
        act = ACT_ISSUE;
        word = C_GO_IDLE;
      end
      MODE_COMPLETE: begin
        case (phase_q)
          PH_CMD0: begin
            if (!item_i.cmd_ok) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_ERROR;
            end else begin
              phase_d = PH_CMD8;
              act = ACT_ISSUE;
              word = C_IF_COND;
              arg = {20'h0, IF_COND_PATTERN};
            end
          end
          PH_CMD8: begin
            // echo mismatch fails, a failed command means a version 1 card
            if (item_i.cmd_ok && (r0[11:0] != IF_COND_PATTERN)) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_ERROR;
            end else begin
              kind_d = item_i.cmd_ok ? KIND_V2 : KIND_V1;
              phase_d = PH_CMD55;
              act = ACT_ISSUE;
              word = C_APP;
              arg = {rca_q, 16'h0};
            end
          end
          PH_CMD55: begin
            if (!item_i.cmd_ok) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_ERROR;
            end else begin
              phase_d = PH_ACMD41;
              act = ACT_ISSUE;
              word = C_OP_COND;
              arg = (kind_q == KIND_V2) ? OCR_ARG_HC : OCR_ARG_SC;
            end
          end
          PH_ACMD41: begin
            if (!item_i.cmd_ok) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_ERROR;
            end else if (r0[OcrBusyBit]) begin
              ocr_we = 1'b1;
              if (r0[OcrCcsBit] && (kind_q == KIND_V2)) begin
                kind_d = KIND_HC;
              end
              phase_d = PH_CMD2;
              act = ACT_ISSUE;
              word = C_SEND_CID;
            end else if (attempts_q == '0) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_TIMEOUT;
            end else begin
              attempts_d = attempts_q - 8'd1;
              phase_d = PH_CMD55;
              act = ACT_ISSUE;
              word = C_APP;
              arg = {rca_q, 16'h0};
            end
          end
          PH_CMD2: begin
            if (!item_i.cmd_ok) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_ERROR;
            end else begin
              cid_we = 1'b1;
              phase_d = PH_CMD3;
              act = ACT_ISSUE;
              word = C_SEND_RCA;
            end
          end
          PH_CMD3: begin
            if (!item_i.cmd_ok) begin
              phase_d = PH_IDLE;
              act = ACT_DONE;
              res = RES_ERROR;
            end else begin
              rca_d = r0[31:16];
              fast_d = 1'b1;
              phase_d = PH_CMD7;
              act = ACT_ISSUE;
              word = C_SELECT;
              arg = {r0[31:16], 16'h0};
            end
          end
          PH_CMD7: begin
            phase_d = item_i.cmd_ok ? PH_READY : PH_IDLE;
            act = ACT_DONE;
            res = item_i.cmd_ok ? RES_OK : RES_ERROR;
          end
          PH_BLOCK: begin
            phase_d = PH_READY;
            act = ACT_DONE;
            res = item_i.cmd_ok ? RES_OK : RES_ERROR;
          end
          default: ;
        endcase
      end
      MODE_BLOCK: begin
        if (phase_q != PH_READY) begin
          act = ACT_DONE;
          res = RES_ERROR;
        end else begin
          phase_d = PH_BLOCK;
          act = ACT_ISSUE;
          word = item_i.is_write ? C_WRITE_ONE : C_READ_ONE;
          arg = (kind_q == KIND_HC) ? item_i.block_address
                                    : (item_i.block_address << BlockShift);
        end
      end
      default: ;
    endcase
  end

  // result fields reflect the state after this event
  always_comb begin
    res_o.action = act;
    res_o.cmd_word = word;
    res_o.cmd_arg = arg;
    res_o.clock_div = fast_d ? cfg_i.data_clock_div : cfg_i.ident_clock_div;
    res_o.card_kind = kind_d;
    res_o.result_code = res;
    res_o.card_ready = phase_d inside {PH_READY, PH_BLOCK};
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q <= KIND_UNKNOWN;
      rca_q <= '0;
      attempts_q <= '0;
      fast_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      kind_q <= kind_d;
      rca_q <= rca_d;
      attempts_q <= attempts_d;
      fast_q <= fast_d;
    end
  end

  // operating conditions register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocr_q <= '0;
    end else if (fire_i && ocr_we) begin
      ocr_q <= r0;
    end
  end

  // card identification words, undefined until the first capture
  always_ff @(posedge clk_i) begin
    if (fire_i && cid_we) begin
      cid_q[0] <= r0;
      cid_q[1] <= item_i.resp_word1;
      cid_q[2] <= item_i.resp_word2;
      cid_q[3] <= item_i.resp_word3;
    end
  end

  assign status_o.phase = phase_q;
  assign status_o.fast_clock = fast_q;

endmodule

/* hw/rtl/sd_card_identify_sequencer.sv */
// sd_card_identify_sequencer: top level of the SD card identification
// sequencer. Depends on sdid_pkg, sdid_if, sdid_pipe_reg, sdid_cfg_regs, sdid_seq.
//
//   channel   dir   handshake      contents
//   in_ch     in    valid/ready    event: mode, cmd_ok, response words, block request
//   out_ch    out   valid/ready    result: action, command word and argument, status
//   cfg_*     in    write enable   retry_limit, ident_clock_div, data_clock_div
//
// One event per cycle sustained while the output accepts; an input register
// is followed by the result register, with the state update at the hop between.
// Reset brings the card phase to idle and the registers to their defaults.
// A stalled output holds its result while one more event waits in the input
// register; ready upstream drops only when both registers are full and stalled.
module sd_card_identify_sequencer
  import sdid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sdid_in_if.sink             in_ch,
  sdid_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // register widths follow the transaction types
  localparam int unsigned InWidth = $bits(in_item_t);
  localparam int unsigned ResWidth = $bits(res_item_t);

  in_item_t      in_pkt, head;
  res_item_t     res_d, res_q;
  cfg_t          cfg;
  seq_status_t   status;
  logic          head_valid, res_in_ready, fire;
  logic [InWidth-1:0]  head_vec;
  logic [ResWidth-1:0] res_vec;

  // pack the incoming transaction
  always_comb begin
    in_pkt.mode = in_ch.mode;
    in_pkt.cmd_ok = in_ch.cmd_ok;
    in_pkt.resp_word0 = in_ch.resp_word0;
    in_pkt.resp_word1 = in_ch.resp_word1;
    in_pkt.resp_word2 = in_ch.resp_word2;
    in_pkt.resp_word3 = in_ch.resp_word3;
    in_pkt.block_address = in_ch.block_address;
    in_pkt.is_write = in_ch.is_write;
  end

  // input register
  sdid_pipe_reg #(
    .Width(InWidth)
  ) u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .in_data_i  (in_pkt),
    .out_valid_o(head_valid),
    .out_ready_i(res_in_ready),
    .out_data_o (head_vec)
  );

  assign head = in_item_t'(head_vec);
  assign fire = head_valid && res_in_ready;

  // configuration registers
  sdid_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // sequence state and next-state logic
  sdid_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (head),
    .cfg_i   (cfg),
    .res_o   (res_d),
    .status_o(status)
  );

  // result register
  sdid_pipe_reg #(
    .Width(ResWidth)
  ) u_res_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (head_valid),
    .in_ready_o (res_in_ready),
    .in_data_i  (res_d),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .out_data_o (res_vec)
  );

  assign res_q = res_item_t'(res_vec);

  // unpack the outgoing transaction
  always_comb begin
    out_ch.action = res_q.action;
    out_ch.cmd_word = res_q.cmd_word;
    out_ch.cmd_arg = res_q.cmd_arg;
    out_ch.clock_div = res_q.clock_div;
    out_ch.card_kind = res_q.card_kind;
    out_ch.result_code = res_q.result_code;
    out_ch.card_ready = res_q.card_ready;
  end

  // a start event always lands in the first command phase
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (head.mode == MODE_START) |=> status.phase == PH_CMD0)
    else $error("start event did not enter the CMD0 phase");

  // a ready card has been typed and runs on the data clock
  a_ready_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.card_ready |->
      (out_ch.card_kind != KIND_UNKNOWN) && (out_ch.clock_div == cfg.data_clock_div))
    else $error("ready card without known type or data clock");

  // ready phases always run with the fast clock selected
  a_ready_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == PH_READY) || (status.phase == PH_BLOCK) |-> status.fast_clock)
    else $error("ready phase with identification clock selected");

  // a timeout leaves the card idle and not ready
  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_d.result_code == RES_TIMEOUT) |=>
      (status.phase == PH_IDLE) && !res_q.card_ready)
    else $error("timeout did not return the sequence to idle");

endmodule

/* tb/sv/sdid_checker.sv */
// sdid_checker: tracks the card identification sequence on its own and checks
// every result transaction of the sequencer against it, in order.
// Depends on sdid_pkg and the sdid_in_if / sdid_out_if channels.
module sdid_checker
  import sdid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sdid_in_if                  in_ch,
  sdid_out_if                 out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         errors_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the configuration and of the card sequence
  cfg_t        cfg_shadow;
  logic [3:0]  seq_phase;
  logic [1:0]  kind;
  logic [15:0] rca;
  logic [31:0] ocr;
  logic [31:0] cid [4];
  logic [7:0]  tries_left;
  logic        on_data_clock;

  // results still owed by the sequencer, oldest first
  res_item_t   sequencer_results [$];

  // result word with the status fields as they stand now
  function automatic res_item_t snapshot(input logic [1:0] act, input logic [31:0] word,
                                         input logic [31:0] arg, input logic [1:0] code);
    res_item_t res;
    res.action      = act;
    res.cmd_word    = word;
    res.cmd_arg     = arg;
    res.clock_div   = on_data_clock ? cfg_shadow.data_clock_div : cfg_shadow.ident_clock_div;
    res.card_kind   = kind;
    res.result_code = code;
    res.card_ready  = seq_phase inside {PH_READY, PH_BLOCK};
    return res;
  endfunction

  // identification aborted: back to idle, type found so far is kept
  function automatic res_item_t drop_to_idle(input logic [1:0] code);
    seq_phase = PH_IDLE;
    return snapshot(ACT_DONE, '0, '0, code);
  endfunction

  // one command completion against the current phase
  function automatic res_item_t complete_command(input in_item_t ev);
    logic        ok;
    logic [31:0] r0;
    res_item_t   res;
    ok = ev.cmd_ok;
    r0 = ev.resp_word0;
    case (seq_phase)
      PH_CMD0: begin
        if (!ok) begin
          res = drop_to_idle(RES_ERROR);
        end else begin
          seq_phase = PH_CMD8;
          res = snapshot(ACT_ISSUE, C_IF_COND, {20'd0, IF_COND_PATTERN}, RES_OK);
        end
      end
      PH_CMD8: begin
        // no response means a version 1 card, a bad echo ends it
        if (ok && (r0[11:0] != IF_COND_PATTERN)) begin
          res = drop_to_idle(RES_ERROR);
        end else begin
          kind = ok ? KIND_V2 : KIND_V1;
          seq_phase = PH_CMD55;
          res = snapshot(ACT_ISSUE, C_APP, {rca, 16'd0}, RES_OK);
        end
      end
      PH_CMD55: begin
        if (!ok) begin
          res = drop_to_idle(RES_ERROR);
        end else begin
          seq_phase = PH_ACMD41;
          res = snapshot(ACT_ISSUE, C_OP_COND, (kind == KIND_V2) ? OCR_ARG_HC : OCR_ARG_SC,
                         RES_OK);
        end
      end
      PH_ACMD41: begin
        if (!ok) begin
          res = drop_to_idle(RES_ERROR);
        end else if (r0[OcrBusyBit]) begin
          ocr = r0;
          if (r0[OcrCcsBit] && (kind == KIND_V2)) kind = KIND_HC;
          seq_phase = PH_CMD2;
          res = snapshot(ACT_ISSUE, C_SEND_CID, '0, RES_OK);
        end else if (tries_left == 8'd0) begin
          res = drop_to_idle(RES_TIMEOUT);
        end else begin
          tries_left = tries_left - 8'd1;
          seq_phase = PH_CMD55;
          res = snapshot(ACT_ISSUE, C_APP, {rca, 16'd0}, RES_OK);
        end
      end
      PH_CMD2: begin
        if (!ok) begin
          res = drop_to_idle(RES_ERROR);
        end else begin
          cid[0] = r0;
          cid[1] = ev.resp_word1;
          cid[2] = ev.resp_word2;
          cid[3] = ev.resp_word3;
          seq_phase = PH_CMD3;
          res = snapshot(ACT_ISSUE, C_SEND_RCA, '0, RES_OK);
        end
      end
      PH_CMD3: begin
        if (!ok) begin
          res = drop_to_idle(RES_ERROR);
        end else begin
          rca = r0[31:16];
          on_data_clock = 1'b1;
          seq_phase = PH_CMD7;
          res = snapshot(ACT_ISSUE, C_SELECT, {rca, 16'd0}, RES_OK);
        end
      end
      PH_CMD7: begin
        if (!ok) begin
          res = drop_to_idle(RES_ERROR);
        end else begin
          seq_phase = PH_READY;
          res = snapshot(ACT_DONE, '0, '0, RES_OK);
        end
      end
      PH_BLOCK: begin
        seq_phase = PH_READY;
        res = snapshot(ACT_DONE, '0, '0, ok ? RES_OK : RES_ERROR);
      end
      default: begin
        // idle or ready: nothing to do
        res = snapshot(ACT_NONE, '0, '0, RES_OK);
      end
    endcase
    return res;
  endfunction

  // one input event, returns the result the sequencer owes for it
  function automatic res_item_t advance_sequence(input in_item_t ev);
    logic [31:0] addr;
    res_item_t   res;
    res = snapshot(ACT_NONE, '0, '0, RES_OK);
    case (ev.mode)
      MODE_START: begin
        kind = KIND_UNKNOWN;
        rca = '0;
        tries_left = cfg_shadow.retry_limit;
        on_data_clock = 1'b0;
        seq_phase = PH_CMD0;
        res = snapshot(ACT_ISSUE, C_GO_IDLE, '0, RES_OK);
      end
      MODE_COMPLETE: res = complete_command(ev);
      MODE_BLOCK: begin
        if (seq_phase != PH_READY) begin
          res = snapshot(ACT_DONE, '0, '0, RES_ERROR);
        end else begin
          // high capacity cards take block numbers, others byte addresses
          addr = (kind == KIND_HC) ? ev.block_address : (ev.block_address << BlockShift);
          seq_phase = PH_BLOCK;
          res = snapshot(ACT_ISSUE, ev.is_write ? C_WRITE_ONE : C_READ_ONE, addr, RES_OK);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors_o++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t  ev;
    res_item_t want;
    if (!rst_ni) begin
      cfg_shadow    = '{RETRY_LIMIT_RST, IDENT_DIV_RST, DATA_DIV_RST};
      seq_phase     = PH_IDLE;
      kind          = KIND_UNKNOWN;
      rca           = '0;
      ocr           = '0;
      tries_left    = '0;
      on_data_clock = 1'b0;
      sequencer_results.delete();
      errors_o      = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RETRY_LIMIT: cfg_shadow.retry_limit = cfg_wdata_i[7:0];
          CFG_IDENT_DIV:   cfg_shadow.ident_clock_div = cfg_wdata_i;
          CFG_DATA_DIV:    cfg_shadow.data_clock_div = cfg_wdata_i;
          default: ;
        endcase
      end
      // result transaction against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (sequencer_results.size() == 0) begin
          $error("result transaction with no result awaited: action %0h word %0h arg %0h",
                 out_ch.action, out_ch.cmd_word, out_ch.cmd_arg);
          errors_o++;
        end else begin
          want = sequencer_results.pop_front();
          check_field("action", want.action, out_ch.action);
          check_field("cmd_word", want.cmd_word, out_ch.cmd_word);
          check_field("cmd_arg", want.cmd_arg, out_ch.cmd_arg);
          check_field("clock_div", want.clock_div, out_ch.clock_div);
          check_field("card_kind", want.card_kind, out_ch.card_kind);
          check_field("result_code", want.result_code, out_ch.result_code);
          check_field("card_ready", want.card_ready, out_ch.card_ready);
        end
      end
      // event transaction: predict its result
      if (in_ch.valid && in_ch.ready) begin
        ev = '{in_ch.mode, in_ch.cmd_ok, in_ch.resp_word0, in_ch.resp_word1,
               in_ch.resp_word2, in_ch.resp_word3, in_ch.block_address, in_ch.is_write};
        sequencer_results.push_back(advance_sequence(ev));
      end
      pending_o = sequencer_results.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: drives card events and register writes into sd_card_identify_sequencer
// and gives the verdict. Depends on it, sdid_pkg, sdid_if and sdid_checker.
module tb_top
  import sdid_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems   = 1150;
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned HoldOffCycles = 80;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned DrainLimit    = 4000;

  typedef enum int unsigned {StallNone, StallCoin, StallSparse, StallPeriodic} stall_style_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int unsigned         errors;
  int unsigned         pending;
  int unsigned         events_sent;
  int unsigned         burst_left;
  int unsigned         hold_requests;
  int unsigned         hold_served;
  int unsigned         quiet_cycles;
  logic [7:0]          retry_setting;

  sdid_in_if  in_ch ();
  sdid_out_if out_ch ();

  sd_card_identify_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sdid_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("sd_card_identify_sequencer verification failed");
        $finish;
      end
    end
  end

  // result side: segments of stall styles, plus long hold-offs on request
  initial begin : result_ready
    int unsigned  seg_left;
    int unsigned  tick;
    stall_style_e style;
    seg_left = 0;
    tick = 0;
    style = StallNone;
    hold_served = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_served != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_served++;
      end else begin
        if (seg_left == 0) begin
          style = stall_style_e'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        tick++;
        case (style)
          StallNone:   out_ch.ready <= 1'b1;
          StallCoin:   out_ch.ready <= 1'($urandom_range(0, 1));
          StallSparse: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     out_ch.ready <= ((tick % 3) != 0);
        endcase
        @(negedge clk_i);
      end
    end
  end

  function automatic bit one_in(input int unsigned n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic logic [9:0] pick_divider();
    case ($urandom_range(0, 3))
      0:       return 10'd0;
      1:       return 10'h3FF;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // event with every field random, callers fix the fields that matter
  function automatic in_item_t any_event();
    in_item_t ev;
    ev.mode          = 2'($urandom_range(0, 2));
    ev.cmd_ok        = 1'($urandom_range(0, 1));
    ev.resp_word0    = $urandom;
    ev.resp_word1    = $urandom;
    ev.resp_word2    = $urandom;
    ev.resp_word3    = $urandom;
    ev.block_address = $urandom;
    ev.is_write      = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  function automatic in_item_t start_event();
    in_item_t ev;
    ev = any_event();
    ev.mode = MODE_START;
    return ev;
  endfunction

  function automatic in_item_t completion(input logic ok, input logic [31:0] r0);
    in_item_t ev;
    ev = any_event();
    ev.mode = MODE_COMPLETE;
    ev.cmd_ok = ok;
    ev.resp_word0 = r0;
    return ev;
  endfunction

  function automatic in_item_t block_request(input logic [31:0] lba, input logic wr);
    in_item_t ev;
    ev = any_event();
    ev.mode = MODE_BLOCK;
    ev.block_address = lba;
    ev.is_write = wr;
    return ev;
  endfunction

  // one event transaction; bursts of random length with random gaps between
  task automatic send_event(input in_item_t ev);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= ev.mode;
    in_ch.cmd_ok        <= ev.cmd_ok;
    in_ch.resp_word0    <= ev.resp_word0;
    in_ch.resp_word1    <= ev.resp_word1;
    in_ch.resp_word2    <= ev.resp_word2;
    in_ch.resp_word3    <= ev.resp_word3;
    in_ch.block_address <= ev.block_address;
    in_ch.is_write      <= ev.is_write;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
    events_sent++;
    @(negedge clk_i);
  endtask

  // wait for the sequencer to go quiet, then write all three registers
  task automatic program_registers(input logic [7:0] retry, input logic [9:0] ident_div,
                                   input logic [9:0] data_div);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RETRY_LIMIT;
    cfg_wdata_i <= {2'b00, retry};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IDENT_DIV;
    cfg_wdata_i <= ident_div;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_DATA_DIV;
    cfg_wdata_i <= data_div;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    retry_setting = retry;
  endtask

  // a full identification with random content and occasional failures
  task automatic walk_identification(output bit reached_ready);
    int unsigned busy_rounds;
    int unsigned pick;
    bit          time_out;
    logic        ok;
    logic [31:0] word;
    reached_ready = 1'b0;
    send_event(start_event());
    if (one_in(20)) begin
      send_event(completion(1'b0, $urandom));
      return;
    end
    send_event(completion(1'b1, $urandom));
    // interface condition: good echo, no response, or bad echo
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      word = $urandom;
      word[11:0] = IF_COND_PATTERN;
      send_event(completion(1'b1, word));
    end else if (pick < 18) begin
      send_event(completion(1'b0, $urandom));
    end else begin
      word = $urandom;
      if (word[11:0] == IF_COND_PATTERN) word[0] = ~word[0];
      send_event(completion(1'b1, word));
      return;
    end
    // op condition polling, sometimes until the attempts run out
    time_out = (retry_setting <= 8'd5) && one_in(5);
    busy_rounds = time_out ? retry_setting + 1
                           : $urandom_range(0, (retry_setting < 8'd3) ? retry_setting : 3);
    repeat (busy_rounds) begin
      ok = !one_in(40);
      send_event(completion(ok, $urandom));
      if (!ok) return;
      word = $urandom;
      word[OcrBusyBit] = 1'b0;
      ok = !one_in(40);
      send_event(completion(ok, word));
      if (!ok) return;
    end
    if (time_out) return;
    send_event(completion(1'b1, $urandom));
    word = $urandom;
    word[OcrBusyBit] = 1'b1;
    send_event(completion(1'b1, word));
    // cid, rca, select
    repeat (3) begin
      ok = !one_in(30);
      send_event(completion(ok, $urandom));
      if (!ok) return;
    end
    reached_ready = 1'b1;
  endtask

  // block requests on a ready card, with some misuse mixed in
  task automatic exercise_blocks();
    logic [31:0] lba;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 7))
        0:       lba = '1;
        1:       lba = '0;
        2:       lba = 32'($urandom_range(0, 255));
        default: lba = $urandom;
      endcase
      send_event(block_request(lba, 1'($urandom_range(0, 1))));
      if (one_in(10)) send_event(block_request($urandom, 1'($urandom_range(0, 1))));
      send_event(completion(!one_in(8), $urandom));
      if (one_in(12)) send_event(completion(1'b1, $urandom));
    end
  endtask

  initial begin : stimulus
    in_item_t    ev;
    int unsigned session;
    int unsigned random_from;
    int unsigned waited;
    bit          selected;
    logic [7:0]  retry;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MODE_START;
    in_ch.cmd_ok        <= 1'b0;
    in_ch.resp_word0    <= '0;
    in_ch.resp_word1    <= '0;
    in_ch.resp_word2    <= '0;
    in_ch.resp_word3    <= '0;
    in_ch.block_address <= '0;
    in_ch.is_write      <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_RETRY_LIMIT;
    cfg_wdata_i         <= '0;
    burst_left = 0;
    events_sent = 0;
    hold_requests = 0;
    retry_setting = RETRY_LIMIT_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no retries, extreme dividers: error paths, timeout, version 1 card
    program_registers(8'd0, 10'h3FF, 10'd0);
    send_event(block_request('1, 1'b1));
    send_event(completion(1'b1, '1));
    send_event(start_event());
    send_event(completion(1'b0, '0));
    send_event(start_event());
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, 32'h0000_01AB));
    send_event(start_event());
    send_event(completion(1'b1, '0));
    send_event(completion(1'b0, '0));
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, 32'h7FFF_FFFF));
    send_event(start_event());
    send_event(completion(1'b1, '0));
    send_event(completion(1'b0, '1));
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, 32'hC000_0000));
    ev = completion(1'b1, '1);
    ev.resp_word1 = '1;
    ev.resp_word2 = '1;
    ev.resp_word3 = '1;
    send_event(ev);
    send_event(completion(1'b1, 32'hFFFF_0000));
    send_event(completion(1'b1, '0));
    send_event(block_request('1, 1'b0));
    send_event(block_request('0, 1'b1));
    send_event(completion(1'b0, '0));

    // one retry, dividers swapped: high capacity card with one busy poll
    program_registers(8'd1, 10'd0, 10'h3FF);
    send_event(start_event());
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, 32'hFFFF_F1AA));
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, '0));
    send_event(completion(1'b1, 32'hC000_0000));
    ev = completion(1'b1, '0);
    ev.resp_word1 = '0;
    ev.resp_word2 = '0;
    ev.resp_word3 = '0;
    send_event(ev);
    send_event(completion(1'b1, 32'h0000_FFFF));
    send_event(completion(1'b1, '0));
    send_event(block_request('1, 1'b1));
    send_event(completion(1'b1, '0));

    // random sessions, each under a fresh register setting
    random_from = events_sent;
    session = 0;
    while (events_sent < random_from + RandomItems) begin
      case ($urandom_range(0, 5))
        0:       retry = 8'd0;
        1:       retry = 8'hFF;
        2:       retry = 8'($urandom_range(0, 255));
        default: retry = 8'($urandom_range(1, 4));
      endcase
      program_registers(retry, pick_divider(), pick_divider());
      if (session == 1) hold_requests++;
      repeat ($urandom_range(2, 5)) begin
        walk_identification(selected);
        if (selected) exercise_blocks();
        if (one_in(4)) repeat ($urandom_range(1, 6)) send_event(any_event());
      end
      session++;
    end

    // drain and verdict
    in_ch.valid <= 1'b0;
    waited = 0;
    while ((pending != 0) && (waited < DrainLimit)) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending != 0) begin
      $display("sd_card_identify_sequencer verification failed");
    end else begin
      repeat (SettleCycles) @(negedge clk_i);
      if (errors == 0) begin
        $display("sd_card_identify_sequencer verification clean");
      end else begin
        $display("sd_card_identify_sequencer verification failed");
      end
    end
    $finish;
  end

endmodule
